// ===== rtl/core/dmxscp_pkg.sv =====
package dmxscp_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned MAX_SLOT     = 512;
  localparam int unsigned NUM_DUTIES   = 4;

  localparam int unsigned SLOT_W  = $clog2(MAX_SLOT + 2);
  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned DUTY_W  = 9;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_DEAD = 8'd2;
  localparam logic [DUTY_W-1:0]  DUTY_CAP   = 9'd499;
  localparam logic [LEVEL_W-1:0] DIMMER_LEAD = 8'h00;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_SLOT);

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_BREAK = 2'd1,
    CMD_SAVE  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0][LEVEL_W-1:0] level;
    logic [NUM_CHANNELS-1:0][LEVEL_W-1:0] offset;
    logic                                 led;
  } chan_state_t;

endpackage

// ===== rtl/core/dmx_slot_capture_offset_pwm.sv =====
// Channel        | Direction | Signals                       | Contents (lowest bit first)
// request in     | slave     | s_axis_tvalid/tready/tdata/tuser | tdata: data[7:0]; tuser: cmd[1:0]
// result out     | master    | m_axis_tvalid/tready/tdata    | duty_ch0..3 (9b each), error_led
// configuration  | write     | cfg_we/cfg_index/cfg_data     | address_ch0..3 by index 0..3
//
// One request per cycle sustained while the output is not stalled; each request gives one result
// through the state stage, which updates slot counter, levels, offsets and LED, and the output
// register, which takes the four mapped duties (one 8x8 multiply per channel).
// Reset (rst_ni low, asynchronous) clears state and sets addresses to 1..4.
// While the output is stalled one more request is taken into the state stage, then
// s_axis_tready_o drops until the output register is drained.
module dmx_slot_capture_offset_pwm (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [7:0]                           s_axis_tdata_i,  // data[7:0]
  input  logic [1:0]                           s_axis_tuser_i,  // cmd[1:0]
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // duty_ch0[8:0], duty_ch1[17:9], duty_ch2[26:18], duty_ch3[35:27], error_led[36]
  output logic [39:0]                          m_axis_tdata_o,
  input  logic                                 cfg_we_i,
  input  logic [dmxscp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dmxscp_pkg::ADDR_W-1:0]        cfg_data_i
);

  localparam int unsigned ND = dmxscp_pkg::NUM_DUTIES;
  localparam int unsigned DW = dmxscp_pkg::DUTY_W;

  dmxscp_pkg::chan_state_t             state;
  logic [ND-1:0][DW-1:0]               duty;
  logic [ND-1:0][DW-1:0]               duty_q;
  logic                                led_q;
  logic                                s1_valid_q;
  logic                                out_valid_q;
  logic                                advance;
  logic                                accept;

  // Advance the state stage into the output register when that register is free.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  dmxscp_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .cmd_i       (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .state_o     (state)
  );

  // Map each present channel; absent channels report zero duty.
  for (genvar g = 0; g < ND; g++) begin : g_duty
    if (g < dmxscp_pkg::NUM_CHANNELS) begin : g_on
      dmxscp_duty u_duty (
        .level_i  (state.level[g]),
        .offset_i (state.offset[g]),
        .duty_o   (duty[g])
      );
    end else begin : g_off
      assign duty[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Load the result payload; hold it while the result waits.
  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      duty_q <= duty;
      led_q  <= state.led;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, led_q, duty_q};

endmodule

// ===== rtl/core/dmxscp_capture.sv =====
module dmxscp_capture (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [1:0]                        cmd_i,
  input  logic [dmxscp_pkg::LEVEL_W-1:0]    data_i,
  input  logic                              cfg_we_i,
  input  logic [dmxscp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dmxscp_pkg::ADDR_W-1:0]     cfg_data_i,
  output dmxscp_pkg::chan_state_t           state_o
);

  localparam int unsigned NCH = dmxscp_pkg::NUM_CHANNELS;

  logic [NCH-1:0][dmxscp_pkg::ADDR_W-1:0]  addr_q;
  logic [dmxscp_pkg::SLOT_W-1:0]           slot_q, slot_d;
  logic [dmxscp_pkg::LEVEL_W-1:0]          start_q, start_d;
  logic [NCH-1:0][dmxscp_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [NCH-1:0][dmxscp_pkg::LEVEL_W-1:0] offset_q, offset_d;
  logic                                    led_q, led_d;
  logic                                    slot_live;

  // Address registers; writes past the channel count are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        addr_q[i] <= dmxscp_pkg::ADDR_W'(i + 1);
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NCH; i++) begin
        if (cfg_index_i == dmxscp_pkg::CFG_IDX_W'(i)) begin
          addr_q[i] <= cfg_data_i;
        end
      end
    end
  end

  assign slot_live = (slot_q <= dmxscp_pkg::SLOT_LAST);

  always_comb begin
    slot_d   = slot_q;
    start_d  = start_q;
    level_d  = level_q;
    offset_d = offset_q;
    led_d    = led_q;
    unique case (cmd_i)
      dmxscp_pkg::CMD_DATA: begin
        if (slot_q == '0) begin
          start_d = data_i;
        end else if (slot_live && start_q == dmxscp_pkg::DIMMER_LEAD) begin
          for (int i = 0; i < NCH; i++) begin
            if (addr_q[i] == dmxscp_pkg::ADDR_W'(slot_q)) begin
              level_d[i] = data_i;
            end
          end
        end
        if (slot_live) begin
          slot_d = slot_q + 1'b1;
        end
      end
      dmxscp_pkg::CMD_BREAK: begin
        slot_d = '0;
        led_d  = ~led_q;
      end
      dmxscp_pkg::CMD_SAVE: begin
        offset_d = level_q;
        led_d    = 1'b0;
      end
      default: begin
        // unused command: hold everything
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      start_q  <= '0;
      level_q  <= '0;
      offset_q <= '0;
      led_q    <= 1'b0;
    end else if (step_i) begin
      slot_q   <= slot_d;
      start_q  <= start_d;
      level_q  <= level_d;
      offset_q <= offset_d;
      led_q    <= led_d;
    end
  end

  assign state_o.level  = level_q;
  assign state_o.offset = offset_q;
  assign state_o.led    = led_q;

endmodule

// ===== rtl/core/dmxscp_duty.sv =====
module dmxscp_duty (
  input  logic [dmxscp_pkg::LEVEL_W-1:0] level_i,
  input  logic [dmxscp_pkg::LEVEL_W-1:0] offset_i,
  output logic [dmxscp_pkg::DUTY_W-1:0]  duty_o
);

  logic [15:0] prod;
  logic [8:0]  sum;
  logic [7:0]  mapped;
  logic [8:0]  raw;

  // Scale the level above the dead band into the span left above the offset.
  assign prod = 16'(level_i - dmxscp_pkg::LEVEL_DEAD) * 16'(dmxscp_pkg::LEVEL_FULL - offset_i);
  assign sum  = {1'b0, offset_i} + {1'b0, prod[15:8]};

  always_comb begin
    if (level_i <= dmxscp_pkg::LEVEL_DEAD) begin
      mapped = '0;
    end else if (level_i == dmxscp_pkg::LEVEL_FULL) begin
      mapped = dmxscp_pkg::LEVEL_FULL;
    end else if (sum[8]) begin
      mapped = dmxscp_pkg::LEVEL_FULL;
    end else begin
      mapped = sum[7:0];
    end
  end

  assign raw    = {mapped, 1'b0} - {6'b0, mapped[7:5]};
  assign duty_o = (raw > dmxscp_pkg::DUTY_CAP) ? dmxscp_pkg::DUTY_CAP : raw;

endmodule

// ===== tb/tb_dmx_slot_capture_offset_pwm.sv =====
module tb_dmx_slot_capture_offset_pwm;
  timeunit 1ns;
  timeprecision 1ps;

  // Code 3 on the command lane is not decoded by the block: it must leave all state alone.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned IDLE_LIMIT = 2000;  // cycles without any handshake
  localparam int unsigned LONG_HOLD  = 300;   // output back-pressure stretch

  // One request on the slave side.
  typedef struct packed {
    logic [1:0]                     cmd;
    logic [dmxscp_pkg::LEVEL_W-1:0] data;
  } dmx_event_t;

  // One result word, laid out as on m_axis_tdata_o[36:0].
  typedef struct packed {
    logic                              led;
    logic [3:0][dmxscp_pkg::DUTY_W-1:0] duty;
  } duty_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                             s_axis_tvalid_i = 1'b0;
  logic                             s_axis_tready_o;
  logic [7:0]                       s_axis_tdata_i  = '0;
  logic [1:0]                       s_axis_tuser_i  = '0;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i = 1'b0;
  logic [39:0]                      m_axis_tdata_o;
  logic                             cfg_we_i        = 1'b0;
  logic [dmxscp_pkg::CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [dmxscp_pkg::ADDR_W-1:0]    cfg_data_i      = '0;

  always #6 clk_i = ~clk_i;

  dmx_slot_capture_offset_pwm dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // data[7:0]
    .s_axis_tuser_i  (s_axis_tuser_i),   // cmd[1:0]
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // duty_ch0[8:0], duty_ch1[17:9], duty_ch2[26:18], duty_ch3[35:27], error_led[36]
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the receiver state, advanced once per accepted request.
  // ---------------------------------------------------------------------------
  logic [dmxscp_pkg::ADDR_W-1:0]  slot_address [dmxscp_pkg::NUM_CHANNELS] =
                                    '{10'd1, 10'd2, 10'd3, 10'd4};
  int unsigned                    slot_pos    = 0;
  logic [dmxscp_pkg::LEVEL_W-1:0] lead_byte   = '0;
  logic [dmxscp_pkg::LEVEL_W-1:0] level_q  [dmxscp_pkg::NUM_CHANNELS] = '{default: '0};
  logic [dmxscp_pkg::LEVEL_W-1:0] offset_q [dmxscp_pkg::NUM_CHANNELS] = '{default: '0};
  logic                           led_q       = 1'b0;

  dmx_event_t   event_queue[$];       // requests waiting for the driver
  duty_report_t pending_reports[$];   // predicted results, oldest first
  int unsigned  events_queued   = 0;
  int unsigned  reports_checked = 0;
  int unsigned  errors          = 0;

  // Map a level through its offset into a PWM duty.
  function automatic logic [dmxscp_pkg::DUTY_W-1:0] channel_duty(
      logic [dmxscp_pkg::LEVEL_W-1:0] lv, logic [dmxscp_pkg::LEVEL_W-1:0] off);
    int unsigned l, o, m, d;
    l = lv;
    o = off;
    if (l <= dmxscp_pkg::LEVEL_DEAD) begin
      m = 0;
    end else if (l == dmxscp_pkg::LEVEL_FULL) begin
      m = 255;
    end else begin
      m = o + (((l - 2) * (255 - o)) >> 8);
      if (m > 255) m = 255;
    end
    d = 2 * m - (m >> 5);
    if (d > dmxscp_pkg::DUTY_CAP) d = dmxscp_pkg::DUTY_CAP;
    return d[dmxscp_pkg::DUTY_W-1:0];
  endfunction

  // Apply one request to the shadow state and return the duties that follow.
  function automatic duty_report_t predict_event(dmx_event_t ev);
    duty_report_t r;
    if (ev.cmd == dmxscp_pkg::CMD_DATA) begin
      if (slot_pos == 0) begin
        lead_byte = ev.data;
      end else if (slot_pos <= dmxscp_pkg::MAX_SLOT &&
                   lead_byte == dmxscp_pkg::DIMMER_LEAD) begin
        // every channel whose address matches latches the byte
        for (int c = 0; c < dmxscp_pkg::NUM_CHANNELS; c++)
          if (slot_address[c] == slot_pos) level_q[c] = ev.data;
      end
      // saturate one past the last slot
      if (slot_pos <= dmxscp_pkg::MAX_SLOT) slot_pos++;
    end else if (ev.cmd == dmxscp_pkg::CMD_BREAK) begin
      slot_pos = 0;
      led_q = ~led_q;
    end else if (ev.cmd == dmxscp_pkg::CMD_SAVE) begin
      offset_q = level_q;
      led_q = 1'b0;
    end
    for (int c = 0; c < 4; c++)
      r.duty[c] = (c < dmxscp_pkg::NUM_CHANNELS) ?
                  channel_duty(level_q[c], offset_q[c]) : '0;
    r.led = led_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_event(logic [1:0] cmd, logic [7:0] data);
    event_queue.push_back('{cmd: cmd, data: data});
    events_queued++;
  endfunction

  // Bias bytes toward the mapping corners: dead zone, one above it, full scale.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(253, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames (break, start code, a few slots, maybe a save),
  // the rest single random requests, including the undecoded command.
  task automatic queue_traffic(int unsigned n);
    int unsigned target, len;
    target = events_queued + n;
    while (events_queued < target) begin
      if ($urandom_range(0, 9) < 8) begin
        add_event(dmxscp_pkg::CMD_BREAK, 8'($urandom));
        add_event(dmxscp_pkg::CMD_DATA,
                  ($urandom_range(0, 4) == 0) ? 8'($urandom) : dmxscp_pkg::DIMMER_LEAD);
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) add_event(dmxscp_pkg::CMD_DATA, pick_level());
        if ($urandom_range(0, 3) == 0) add_event(dmxscp_pkg::CMD_SAVE, 8'($urandom));
      end else begin
        add_event(2'($urandom), 8'($urandom));
      end
    end
  endtask

  // Write one address register; only called while the block is drained.
  task automatic write_address(int unsigned idx, logic [dmxscp_pkg::ADDR_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= dmxscp_pkg::CFG_IDX_W'(idx);
    cfg_data_i  <= value;
    slot_address[idx] = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Hold until every queued request has come back checked, then settle.
  task automatic wait_drained();
    wait (reports_checked == events_queued);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued requests, with a random gap after each handshake.
  // ---------------------------------------------------------------------------
  dmx_event_t  cur_event;
  int unsigned gap_left   = 0;
  bit          src_steady = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : driver
    logic offer;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      gap_left = 0;
    end else begin
      offer = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_reports.push_back(predict_event(cur_event));
        offer = 1'b0;
        // switch now and then between gapped traffic and back-to-back bursts
        if ($urandom_range(0, 39) == 0) src_steady = ~src_steady;
        gap_left = src_steady ? 0 : $urandom_range(0, 13);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (event_queue.size() > 0) begin
          cur_event = event_queue.pop_front();
          s_axis_tdata_i <= cur_event.data;
          s_axis_tuser_i <= cur_event.cmd;
          offer = 1'b1;
        end
      end
      s_axis_tvalid_i <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result, then stall ready for a random count. At result
  // 200 and every 400 results after, hold ready low for a long stretch so the
  // block fills and drops s_axis_tready_o while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int unsigned results_seen = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  bit          snk_steady   = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    duty_report_t got, want;
    logic         rdy;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      rdy = 1'b1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = duty_report_t'(m_axis_tdata_o[36:0]);
        results_seen++;
        if (pending_reports.size() == 0) begin
          $display("%0t: result with no request pending: expected none, actual %h",
                   $time, got);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          for (int c = 0; c < 4; c++)
            if (got.duty[c] !== want.duty[c]) begin
              $display("%0t: duty_ch%0d mismatch: expected %0d, actual %0d",
                       $time, c, want.duty[c], got.duty[c]);
              errors++;
            end
          if (got.led !== want.led) begin
            $display("%0t: error_led mismatch: expected %0d, actual %0d",
                     $time, want.led, got.led);
            errors++;
          end
          reports_checked++;
        end
        if (results_seen % 400 == 200) begin
          hold_left = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 39) == 0) snk_steady = ~snk_steady;
          stall_left = snk_steady ? 0 : $urandom_range(0, 13);
        end
        rdy = (hold_left == 0 && stall_left == 0);
      end else if (hold_left > 0) begin
        hold_left--;
        rdy = (hold_left == 0);
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = (stall_left == 0);
      end
      m_axis_tready_i <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither side moves for too long.
  // ---------------------------------------------------------------------------
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed frames on reset addresses, a full-length frame with the
  // address extremes, overlapping addresses, then random address sets.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Undecoded command first, then a dimmer frame with level corners.
    add_event(CMD_UNUSED, 8'hFF);
    add_event(dmxscp_pkg::CMD_BREAK, 8'h00);
    add_event(dmxscp_pkg::CMD_DATA, dmxscp_pkg::DIMMER_LEAD);
    add_event(dmxscp_pkg::CMD_DATA, 8'd255);
    add_event(dmxscp_pkg::CMD_DATA, 8'd254);
    add_event(dmxscp_pkg::CMD_DATA, 8'd3);
    add_event(dmxscp_pkg::CMD_DATA, 8'd2);
    // Save turns the levels into offsets and clears the LED.
    add_event(dmxscp_pkg::CMD_SAVE, 8'hFF);
    // Two breaks in a row toggle the LED twice.
    add_event(dmxscp_pkg::CMD_BREAK, 8'hAA);
    add_event(dmxscp_pkg::CMD_BREAK, 8'h55);
    add_event(dmxscp_pkg::CMD_DATA, dmxscp_pkg::DIMMER_LEAD);
    add_event(dmxscp_pkg::CMD_DATA, 8'd128);
    add_event(dmxscp_pkg::CMD_DATA, 8'd3);
    add_event(dmxscp_pkg::CMD_DATA, 8'd255);
    add_event(dmxscp_pkg::CMD_DATA, 8'd0);
    add_event(CMD_UNUSED, 8'h00);
    // Nonzero start code: the following slots must not be captured.
    add_event(dmxscp_pkg::CMD_BREAK, 8'h00);
    add_event(dmxscp_pkg::CMD_DATA, 8'hFF);
    add_event(dmxscp_pkg::CMD_DATA, 8'd7);
    add_event(dmxscp_pkg::CMD_DATA, 8'd1);
    add_event(dmxscp_pkg::CMD_SAVE, 8'h00);
    // A data byte after the save: slot counting carries on and the nonzero start code still blocks capture.
    add_event(dmxscp_pkg::CMD_DATA, 8'd200);
    wait_drained();

    // The last two slots of the range, plus two addresses that never match.
    write_address(0, 10'd512);
    write_address(1, 10'd511);
    write_address(2, 10'd0);
    write_address(3, 10'd1023);
    add_event(dmxscp_pkg::CMD_BREAK, 8'h00);
    add_event(dmxscp_pkg::CMD_DATA, dmxscp_pkg::DIMMER_LEAD);
    // Run past the last slot so the counter saturates and later bytes drop.
    for (int k = 0; k < dmxscp_pkg::MAX_SLOT + 3; k++)
      add_event(dmxscp_pkg::CMD_DATA, pick_level());
    add_event(dmxscp_pkg::CMD_SAVE, 8'h00);
    queue_traffic(60);
    wait_drained();

    // Two channels on one slot, the others on slots 6 and 1.
    write_address(0, 10'd5);
    write_address(1, 10'd5);
    write_address(2, 10'd6);
    write_address(3, 10'd1);
    queue_traffic(100);
    wait_drained();

    // Random address sets in the reach of short frames, rarely out of range.
    for (int p = 0; p < 3; p++) begin
      for (int c = 0; c < dmxscp_pkg::NUM_CHANNELS; c++)
        write_address(c, ($urandom_range(0, 9) == 0) ? 10'($urandom) :
                         10'($urandom_range(1, 9)));
      queue_traffic(100);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
